// ===== rtl/core/lhc_pkg.sv =====
// Package for the latency histogram counters: payload structs, controller
// command/status structs, geometry constants and the delay binning function.
// No dependencies.
`default_nettype none

package lhc_pkg;

  localparam int NUM_KINDS    = 13;
  localparam int NUM_OUTCOMES = 64;
  localparam int NUM_BUCKETS  = 7;
  localparam int TOTAL_CELLS  = NUM_KINDS * NUM_OUTCOMES * NUM_BUCKETS;
  localparam int ADDR_W       = $clog2(TOTAL_CELLS);
  localparam int CNT_W        = 31;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic {
    OP_RECORD     = 1'b0,
    OP_READ_CLEAR = 1'b1
  } lhc_op_e;

  typedef struct packed {
    logic        op;
    logic [3:0]  api_kind;
    logic [5:0]  outcome_slot;
    logic [31:0] delay_ms;
    logic [2:0]  bucket_pick;
  } lhc_in_t;

  typedef struct packed {
    logic [30:0] count_value;
    logic [2:0]  bucket_used;
    logic        is_success;
  } lhc_out_t;

  typedef struct packed {
    logic clr_we;     // clearing pass: zero one entry
    logic load_item;  // capture the input item
    logic rd_en;      // read the addressed counter
    logic commit;     // write back and load the output register
  } lhc_cmd_t;

  typedef struct packed {
    logic clr_last;   // clearing pass is at the last entry
  } lhc_sts_t;

  // Lower edge of bucket k (k >= 1): 2, 10, then 50*(k-2).
  function automatic logic [31:0] bucket_edge(int k);
    int e;
    if (k == 1) begin
      e = 2;
    end else if (k == 2) begin
      e = 10;
    end else begin
      e = 50 * (k - 2);
    end
    return 32'(e);
  endfunction

  // Bucket = number of lower edges at or below the delay; caps at NUM_BUCKETS-1.
  function automatic logic [2:0] bin_delay(logic [31:0] d);
    logic [2:0] b;
    b = '0;
    for (int k = 1; k < NUM_BUCKETS; k++) begin
      if (d >= bucket_edge(k)) begin
        b = b + 3'd1;
      end
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/latency_histogram_counters.sv =====
// Latency histogram counters, top level: wires controller and datapath.
// Depends on lhc_pkg, lhc_ctrl, lhc_datapath (with lhc_ram).
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_data_i): one item per transfer,
//   either a record (bin delay, saturating increment, return new count) or a
//   read-and-clear (return count, zero it). Items outside the counter array
//   return a count of zero and touch nothing.
//   Output channel (out_valid_o/out_ready_i, out_data_o): one result per item,
//   in order, held in an output register.
//   Config channel (cfg_valid_i/cfg_ready_o, cfg_data_i): writes the success
//   outcome index; always ready. Write only while idle.
//   Timing: an item is taken, the counter memory is read (registered read)
//   in the next cycle, and the write-back and result load follow in the
//   update state once the output register is free. The block takes no new
//   item until the previous one has been written back, as the capture,
//   read and write-back sequence on the counter memory runs in turn.
//   Reset: the counter memory is swept to zero, one entry per cycle, over all
//   TOTAL_CELLS (5824) entries; in_ready_o stays low during the sweep.
//   Stall: while a result waits, the next item may be taken and read; its
//   update waits until the output register frees.
`default_nettype none

module latency_histogram_counters (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire lhc_pkg::lhc_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output lhc_pkg::lhc_out_t     out_data_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [5:0]       cfg_data_i
);
  import lhc_pkg::*;

  lhc_cmd_t cmd;
  lhc_sts_t sts;

  assign cfg_ready_o = 1'b1;

  lhc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lhc_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .in_data_i (in_data_i),
    .cfg_we_i  (cfg_valid_i & cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .out_data_o(out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/lhc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module lhc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lhc_datapath.sv =====
// Datapath: item capture, bucket binning, counter address, saturating update,
// clear sweep counter, success register and output payload register.
// Depends on lhc_pkg and lhc_ram.
`default_nettype none

module lhc_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lhc_pkg::lhc_cmd_t cmd_i,
  output lhc_pkg::lhc_sts_t      sts_o,
  input  wire lhc_pkg::lhc_in_t  in_data_i,
  input  wire logic              cfg_we_i,
  input  wire logic [5:0]        cfg_data_i,
  output lhc_pkg::lhc_out_t      out_data_o
);
  import lhc_pkg::*;

  logic              op_q;
  logic [3:0]        kind_q;
  logic [5:0]        slot_q;
  logic [2:0]        bucket_q;
  logic [5:0]        success_q;
  logic [ADDR_W-1:0] clr_cnt_q;
  lhc_out_t          out_q;

  logic              in_range;
  logic [31:0]       idx;
  logic [ADDR_W-1:0] item_addr;
  logic [CNT_W-1:0]  rd_data;
  logic [CNT_W-1:0]  inc_val;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CNT_W-1:0]  ram_wdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q     <= in_data_i.op;
      kind_q   <= in_data_i.api_kind;
      slot_q   <= in_data_i.outcome_slot;
      bucket_q <= (in_data_i.op == OP_READ_CLEAR) ? in_data_i.bucket_pick
                                                  : bin_delay(in_data_i.delay_ms);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      success_q <= '0;
      clr_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        success_q <= cfg_data_i;
      end
      if (cmd_i.clr_we) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == ADDR_W'(TOTAL_CELLS - 1));

  assign in_range = (32'(kind_q) < NUM_KINDS) && (32'(slot_q) < NUM_OUTCOMES) &&
                    (32'(bucket_q) < NUM_BUCKETS);
  assign idx = (32'(kind_q) * NUM_OUTCOMES + 32'(slot_q)) * NUM_BUCKETS + 32'(bucket_q);
  assign item_addr = in_range ? idx[ADDR_W-1:0] : '0;

  assign inc_val = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;

  assign ram_we    = cmd_i.clr_we | (cmd_i.commit & in_range);
  assign ram_waddr = cmd_i.clr_we ? clr_cnt_q : item_addr;
  assign ram_wdata = (cmd_i.clr_we || op_q == OP_READ_CLEAR) ? '0 : inc_val;

  lhc_ram #(
    .Width(CNT_W),
    .Depth(TOTAL_CELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(item_addr),
    .rdata_o(rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.count_value <= !in_range ? '0 : (op_q == OP_READ_CLEAR) ? rd_data : inc_val;
      out_q.bucket_used <= bucket_q;
      out_q.is_success  <= (slot_q == success_q);
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/lhc_ctrl.sv =====
// Controller: clear sweep after reset, then accept / read / update sequencing
// and the output valid flag. Depends on lhc_pkg.
`default_nettype none

module lhc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire lhc_pkg::lhc_sts_t sts_i,
  output lhc_pkg::lhc_cmd_t      cmd_o
);
  import lhc_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   in_xfer;
  logic   commit;

  assign in_xfer = in_valid_i && (state_q == ST_IDLE);
  assign commit  = (state_q == ST_UPDATE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (sts_i.clr_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (commit) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_CLEAR;
      endcase
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign cmd_o.clr_we    = (state_q == ST_CLEAR);
  assign cmd_o.load_item = in_xfer;
  assign cmd_o.rd_en     = (state_q == ST_READ);
  assign cmd_o.commit    = commit;

  a_accept_to_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_READ))
    else $error("accepted item did not move to read");

  a_rise_from_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_UPDATE))
    else $error("output valid rose outside update");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && out_valid_q && !out_ready_i) |=> (state_q == ST_UPDATE))
    else $error("update left while output stalled");

  a_no_item_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_we |-> (!cmd_o.commit && !cmd_o.rd_en && !out_valid_q))
    else $error("item activity during clearing pass");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking bench for latency_histogram_counters: random and directed items
// on the valid/ready channels, checked against an in-bench histogram predictor.
// Depends on lhc_pkg and the latency_histogram_counters RTL.
`timescale 1ns / 100ps

module testbench;
  import lhc_pkg::*;

  localparam int QUIET_LIMIT = 40000;  // covers the clearing sweep after reset
  localparam int PHASE_ITEMS = 100;
  localparam int HOLD_AT     = 200;    // result count that triggers the long hold
  localparam int LONG_HOLD   = 100;

  typedef struct {
    lhc_in_t item;
    bit      drain;  // wait for all results before offering this one
  } stim_entry_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  lhc_in_t    in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  lhc_out_t   out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [5:0] cfg_data_i = '0;

  logic [CNT_W-1:0] hist_counts [NUM_KINDS][NUM_OUTCOMES][NUM_BUCKETS];
  logic [5:0]       success_slot = '0;
  stim_entry_t      pending_items[$];
  lhc_out_t         expected_tallies[$];
  int               mismatch_count = 0;
  int               items_sent = 0;
  int               results_seen = 0;
  int               quiet_cycles = 0;
  bit               idle_on = 1'b1;

  latency_histogram_counters uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Bin the delay (or take the picked bucket), bump or read-and-clear the counter.
  function automatic lhc_out_t tally_event(lhc_in_t it);
    lhc_out_t   r;
    logic [2:0] b;
    logic [32:0] q;
    r = '0;
    if (it.op == OP_RECORD) begin
      if (it.delay_ms < 2) begin
        b = 3'd0;
      end else if (it.delay_ms < 10) begin
        b = 3'd1;
      end else if (it.delay_ms < 50) begin
        b = 3'd2;
      end else begin
        q = {1'b0, it.delay_ms} / 50 + 2;
        b = (q > NUM_BUCKETS - 1) ? 3'(NUM_BUCKETS - 1) : q[2:0];
      end
    end else begin
      b = it.bucket_pick;
    end
    r.bucket_used = b;
    r.is_success  = (it.outcome_slot == success_slot);
    if (it.api_kind < NUM_KINDS && it.outcome_slot < NUM_OUTCOMES && b < NUM_BUCKETS) begin
      if (it.op == OP_RECORD) begin
        if (hist_counts[it.api_kind][it.outcome_slot][b] != COUNT_MAX)
          hist_counts[it.api_kind][it.outcome_slot][b] =
            hist_counts[it.api_kind][it.outcome_slot][b] + 1'b1;
        r.count_value = hist_counts[it.api_kind][it.outcome_slot][b];
      end else begin
        r.count_value = hist_counts[it.api_kind][it.outcome_slot][b];
        hist_counts[it.api_kind][it.outcome_slot][b] = '0;
      end
    end
    return r;
  endfunction

  task automatic log_mismatch(string what, lhc_out_t want, lhc_out_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%s: expected count=%0d bucket=%0d success=%0b, got count=%0d bucket=%0d success=%0b",
               what, want.count_value, want.bucket_used, want.is_success,
               got.count_value, got.bucket_used, got.is_success);
  endtask

  task automatic queue_item(logic op, logic [3:0] kind, logic [5:0] slot,
                            logic [31:0] delay, logic [2:0] pick, bit drain);
    stim_entry_t e;
    e.item.op           = op;
    e.item.api_kind     = kind;
    e.item.outcome_slot = slot;
    e.item.delay_ms     = delay;
    e.item.bucket_pick  = pick;
    e.drain             = drain;
    pending_items.push_back(e);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid_i || expected_tallies.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Driver: one transfer per item, random gap before each offer.
  always @(posedge clk_i) begin : tx_side
    int  gap_left;
    bit  vld;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_tallies.push_back(tally_event(in_data_i));
        items_sent++;
        if (items_sent % 32 == 0) idle_on = ($urandom_range(0, 3) != 0);
        gap_left = idle_on ? $urandom_range(0, 16) : 0;
      end
      if (!(in_valid_i && !in_ready_o)) begin
        vld = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() != 0 &&
                     !(pending_items[0].drain && expected_tallies.size() != 0)) begin
          in_data_i <= pending_items[0].item;
          pending_items.pop_front();
          vld = 1'b1;
        end
        in_valid_i <= vld;
      end
    end
  end

  // Monitor: compare each result with the oldest prediction, random stalls.
  always @(posedge clk_i) begin : rx_side
    lhc_out_t want;
    int       rx_hold;
    bit       rdy;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_tallies.size() == 0) begin
          log_mismatch("unexpected result", '0, out_data_o);
        end else begin
          want = expected_tallies.pop_front();
          if (want.count_value !== out_data_o.count_value ||
              want.bucket_used !== out_data_o.bucket_used ||
              want.is_success  !== out_data_o.is_success)
            log_mismatch("result mismatch", want, out_data_o);
        end
        results_seen++;
        if (results_seen == HOLD_AT) rx_hold = LONG_HOLD;
        else rx_hold = idle_on ? $urandom_range(0, 16) : 0;
      end
      rdy = 1'b1;
      if (rx_hold > 0) begin
        rx_hold--;
        rdy = 1'b0;
      end
      out_ready_i <= rdy;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    logic [5:0]  phase_slot [4];
    logic [5:0]  hot_slot [4];
    logic [3:0]  hot_kind [3];
    logic [31:0] d;
    logic        op;
    logic [3:0]  kind;
    logic [5:0]  slot;
    logic [2:0]  pick;
    foreach (hist_counts[k, o, b]) hist_counts[k][o][b] = '0;
    phase_slot[0] = 6'd63;
    phase_slot[1] = 6'd0;
    phase_slot[2] = 6'($urandom_range(1, 62));
    phase_slot[3] = 6'd63;
    hot_kind[0] = 4'd0;
    hot_kind[1] = 4'd7;
    hot_kind[2] = 4'(NUM_KINDS - 1);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every bucket edge, saturation-free reads, out-of-range cases.
    queue_item(OP_RECORD, 4'd0, 6'd0, 32'd0, 3'd7, 1'b0);
    queue_item(OP_RECORD, 4'd0, 6'd0, 32'd1, 3'd0, 1'b0);
    queue_item(OP_RECORD, 4'd0, 6'd0, 32'd2, 3'd0, 1'b0);
    queue_item(OP_RECORD, 4'd0, 6'd0, 32'd9, 3'd0, 1'b0);
    queue_item(OP_RECORD, 4'd0, 6'd0, 32'd10, 3'd0, 1'b0);
    queue_item(OP_RECORD, 4'd0, 6'd0, 32'd49, 3'd0, 1'b0);
    queue_item(OP_RECORD, 4'd0, 6'd0, 32'd50, 3'd0, 1'b0);
    queue_item(OP_RECORD, 4'd0, 6'd0, 32'd99, 3'd0, 1'b0);
    queue_item(OP_RECORD, 4'd0, 6'd0, 32'd100, 3'd0, 1'b0);
    queue_item(OP_RECORD, 4'd0, 6'd0, 32'd199, 3'd0, 1'b0);
    queue_item(OP_RECORD, 4'd0, 6'd0, 32'd200, 3'd0, 1'b0);
    queue_item(OP_RECORD, 4'd0, 6'd0, 32'hFFFF_FFFF, 3'd0, 1'b0);
    queue_item(OP_RECORD, 4'(NUM_KINDS - 1), 6'd63, 32'd150, 3'd5, 1'b0);
    queue_item(OP_RECORD, 4'd15, 6'd0, 32'd5, 3'd0, 1'b0);  // kind beyond array
    for (int b = 0; b < 8; b++)  // bucket 7 is beyond the array
      queue_item(OP_READ_CLEAR, 4'd0, 6'd0, 32'hFFFF_FFFF, 3'(b), 1'b0);
    queue_item(OP_READ_CLEAR, 4'd0, 6'd0, 32'd0, 3'd0, 1'b0);  // already cleared
    queue_item(OP_READ_CLEAR, 4'(NUM_KINDS - 1), 6'd63, 32'd0, 3'd5, 1'b0);
    queue_item(OP_READ_CLEAR, 4'd15, 6'd63, 32'd0, 3'd6, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      @(posedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_data_i  <= phase_slot[ph];
      do @(posedge clk_i); while (!cfg_ready_o);
      cfg_valid_i <= 1'b0;
      success_slot = phase_slot[ph];

      hot_slot[0] = phase_slot[ph];
      hot_slot[1] = 6'd0;
      hot_slot[2] = 6'd63;
      hot_slot[3] = 6'($urandom_range(0, 63));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        op   = ($urandom_range(0, 99) < 35) ? OP_READ_CLEAR : OP_RECORD;
        kind = ($urandom_range(0, 9) < 8) ? hot_kind[$urandom_range(0, 2)]
                                          : 4'($urandom_range(0, 15));
        slot = ($urandom_range(0, 9) < 7) ? hot_slot[$urandom_range(0, 3)]
                                          : 6'($urandom_range(0, 63));
        case ($urandom_range(0, 6))
          0: d = $urandom_range(0, 1);
          1: d = $urandom_range(2, 9);
          2: d = $urandom_range(10, 49);
          3: d = $urandom_range(50, 199);
          4: d = $urandom_range(200, 5000);
          5: d = $urandom;
          default: d = $urandom_range(0, 300);
        endcase
        pick = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
        queue_item(op, kind, slot, d, pick, (ph == 1 && i == 50));
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (expected_tallies.size() != 0)
      log_mismatch("missing result", expected_tallies[0], '0);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
